[sv/lpfs_pkg.sv]
// Shared types, constants and codes for the length-prefixed frame splitter.
// No dependencies; every other file except lpfs_fifo imports this package.
package lpfs_pkg;

  localparam int CHANNELS_DEFAULT = 64;
  localparam int CHANNEL_W        = 6;
  localparam int MIDQ_DEPTH       = 2;
  localparam int OUTQ_DEPTH       = 2;

  localparam logic [15:0] MAX_LEN_RESET = 16'd8192;
  localparam logic [7:0]  SOF_SHORT     = 8'hC1;
  localparam logic [7:0]  SOF_LONG      = 8'hC2;
  localparam logic [15:0] MIN_FRAME_LEN = 16'd3;

  // byte offsets inside the header
  localparam logic [15:0] POS_START     = 16'd0;
  localparam logic [15:0] POS_LEN_HI    = 16'd1;
  localparam logic [15:0] POS_LEN_LO    = 16'd2;
  localparam logic [15:0] POS_CODE_SHRT = 16'd3;
  localparam logic [15:0] POS_CODE_LONG = 16'd4;

  typedef logic [1:0] err_kind_t;
  localparam err_kind_t ERR_NONE   = 2'd0;
  localparam err_kind_t ERR_START  = 2'd1;
  localparam err_kind_t ERR_LENGTH = 2'd2;

  typedef struct packed {
    logic [CHANNEL_W-1:0] channel;
    logic [7:0]           data_byte;
    logic                 restart;
    logic                 in_range;
  } lpfs_item_t;

  typedef struct packed {
    logic        locked;
    logic        long_hdr;
    logic [15:0] pos;
    logic [15:0] len;
    logic [7:0]  code;
  } lpfs_ctx_t;

  typedef struct packed {
    logic [CHANNEL_W-1:0] out_channel;
    logic [7:0]           out_byte;
    logic                 in_frame;
    logic                 frame_first;
    logic                 frame_last;
    logic [15:0]          frame_length;
    logic [7:0]           frame_code;
    err_kind_t            error_kind;
  } lpfs_result_t;

endpackage

[sv/length_prefixed_frame_splitter.sv]
// Top level of the length-prefixed frame splitter: front end, back end,
// result queue and the max-length register. Depends on lpfs_pkg and below.
//
// Path: an accepted item passes through the input queue, then the context
//   stage, into the result queue before it shows on the result ports.
// Throughput: 1 item per cycle sustained while the result queue has room,
//   any channel mix; set by the context RAM read-modify-write, which forwards
//   the previous item's context when both hit the same channel.
// Reset: queues empty, every channel context reads idle and unlocked
//   (valid bits cleared at once, no clearing pass), max length back to 8192.
module length_prefixed_frame_splitter
  import lpfs_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 max_frame_length_we,
  input  logic [15:0]          max_frame_length,
  // input queue side
  input  logic                 push,
  output logic                 full,
  input  logic [CHANNEL_W-1:0] channel,
  input  logic [7:0]           data_byte,
  input  logic                 restart,
  // result queue side
  output logic                 empty,
  input  logic                 pop,
  output logic [CHANNEL_W-1:0] out_channel,
  output logic [7:0]           out_byte,
  output logic                 in_frame,
  output logic                 frame_first,
  output logic                 frame_last,
  output logic [15:0]          frame_length,
  output logic [7:0]           frame_code,
  output logic [1:0]           error_kind
);

  logic [15:0]  max_len;      // length limit; lengths at or above it are errors
  lpfs_item_t   q_item;       // head of the front-to-back item queue
  logic         q_empty;
  logic         q_pop;
  logic         res_valid;    // back end has a result for the output queue
  lpfs_result_t res;
  logic         res_full;
  lpfs_result_t out_res;

  // Config register. The user must write it only while idle (not enforced here), so no shadowing is needed.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (max_frame_length_we) begin
      max_len <= max_frame_length;
    end
  end

  // Front: accepts items, marks out-of-range channels, drops restarts that
  // have nothing to clear, and buffers items so the back end may stall.
  lpfs_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .channel  (channel),
    .data_byte(data_byte),
    .restart  (restart),
    .q_pop    (q_pop),
    .q_item   (q_item),
    .q_empty  (q_empty)
  );

  // Back: context lookup, header parse, error locking and result build.
  lpfs_back #(
    .CHANNELS(CHANNELS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .max_len  (max_len),
    .q_item   (q_item),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .res_valid(res_valid),
    .res      (res),
    .res_full (res_full)
  );

  // Result queue: decouples the consumer so a held result does not stop
  // intake.
  lpfs_fifo #(
    .WIDTH($bits(lpfs_result_t)),
    .DEPTH(OUTQ_DEPTH)
  ) u_outq (
    .clk  (clk),
    .rst  (rst),
    .push (res_valid),
    .wdata(res),
    .full (res_full),
    .pop  (pop),
    .rdata(out_res),
    .empty(empty)
  );

  assign out_channel  = out_res.out_channel;
  assign out_byte     = out_res.out_byte;
  assign in_frame     = out_res.in_frame;
  assign frame_first  = out_res.frame_first;
  assign frame_last   = out_res.frame_last;
  assign frame_length = out_res.frame_length;
  assign frame_code   = out_res.frame_code;
  assign error_kind   = out_res.error_kind;

endmodule

[sv/lpfs_fifo.sv]
// Small flop-based queue, first-word fall-through.
// Depends on nothing; DEPTH must be a power of two, at least 2.
module lpfs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/lpfs_front.sv]
// Front end: takes input items, tags channel range, drops no-op restarts,
// and queues the rest for the back end. Depends on lpfs_pkg, lpfs_fifo.
module lpfs_front
  import lpfs_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [CHANNEL_W-1:0] channel,
  input  logic [7:0]           data_byte,
  input  logic                 restart,
  input  logic                 q_pop,
  output lpfs_item_t           q_item,
  output logic                 q_empty
);

  lpfs_item_t item;
  logic       drop;

  always_comb begin
    item.channel   = channel;
    item.data_byte = data_byte;
    item.restart   = restart;
    item.in_range  = (32'(channel) < CHANNELS);
  end

  // restart on a channel that has no context: nothing to do, no result
  assign drop = restart && !item.in_range;

  lpfs_fifo #(
    .WIDTH($bits(lpfs_item_t)),
    .DEPTH(MIDQ_DEPTH)
  ) u_midq (
    .clk  (clk),
    .rst  (rst),
    .push (push && !drop),
    .wdata(item),
    .full (full),
    .pop  (q_pop),
    .rdata(q_item),
    .empty(q_empty)
  );

endmodule

[sv/lpfs_back.sv]
// Back end: per-channel context RAM read-modify-write and result build.
// Depends on lpfs_pkg.
module lpfs_back
  import lpfs_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [15:0]  max_len,
  input  lpfs_item_t   q_item,
  input  logic         q_empty,
  output logic         q_pop,
  output logic         res_valid,
  output lpfs_result_t res,
  input  logic         res_full
);

  localparam int CH_SPAN = 1 << CHANNEL_W;
  localparam int DEPTH   = (CHANNELS < CH_SPAN) ? CHANNELS : CH_SPAN;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  lpfs_ctx_t        ctx_mem [DEPTH];
  lpfs_ctx_t        mem_q;
  logic [DEPTH-1:0] vld;
  logic             vld_q;
  logic             byp_q;
  lpfs_ctx_t        byp_ctx;

  lpfs_item_t       s2_item;
  logic             s2_valid;
  logic             adv;
  logic             s2_wr;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;

  lpfs_ctx_t   cur;
  lpfs_ctx_t   ctx_next;
  logic [15:0] p;
  logic [15:0] len_new;
  logic [7:0]  code_new;
  logic        long_new;
  logic        len_known;
  logic        err_start;
  logic        bad_len;
  logic        have_len;
  logic [16:0] pos_inc;

  assign rd_idx = q_item.channel[IDX_W-1:0];
  assign wr_idx = s2_item.channel[IDX_W-1:0];

  assign res_valid = s2_valid && !s2_item.restart;
  assign adv       = !res_valid || !res_full;
  assign q_pop     = adv && !q_empty;
  assign s2_wr     = s2_valid && adv && s2_item.in_range;

  // stage 2 holds one item; moves whenever it has no result or the result can leave
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_item <= q_item;
      mem_q   <= ctx_mem[rd_idx];
      vld_q   <= vld[rd_idx];
      byp_q   <= s2_wr && (wr_idx == rd_idx);
      byp_ctx <= ctx_next;
    end
    if (s2_wr) begin
      ctx_mem[wr_idx] <= ctx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (s2_wr) begin
      vld[wr_idx] <= 1'b1;
    end
  end

  // context as seen by stage 2: same-edge write wins, unwritten reads idle
  always_comb begin
    if (byp_q) begin
      cur = byp_ctx;
    end else if (vld_q) begin
      cur = mem_q;
    end else begin
      cur = '0;
    end
  end

  always_comb begin
    p         = cur.pos;
    len_new   = cur.len;
    code_new  = cur.code;
    long_new  = cur.long_hdr;
    len_known = 1'b0;
    err_start = 1'b0;
    if (p == POS_START) begin
      len_new  = '0;
      code_new = '0;
      priority if (s2_item.data_byte == SOF_SHORT) begin
        long_new = 1'b0;
      end else if (s2_item.data_byte == SOF_LONG) begin
        long_new = 1'b1;
      end else begin
        err_start = 1'b1;
      end
    end else if (!cur.long_hdr) begin
      if (p == POS_LEN_HI) begin
        len_new   = {8'h00, s2_item.data_byte};
        len_known = 1'b1;
      end else if (p == POS_CODE_SHRT) begin
        code_new = s2_item.data_byte;
      end
    end else begin
      if (p == POS_LEN_HI) begin
        len_new = {s2_item.data_byte, 8'h00};
      end else if (p == POS_LEN_LO) begin
        len_new   = {cur.len[15:8], s2_item.data_byte};
        len_known = 1'b1;
      end else if (p == POS_CODE_LONG) begin
        code_new = s2_item.data_byte;
      end
    end
    bad_len  = len_known && ((len_new < MIN_FRAME_LEN) || (len_new >= max_len));
    have_len = long_new ? (p >= POS_LEN_LO) : (p >= POS_LEN_HI);
    pos_inc  = {1'b0, p} + 17'd1;

    res.out_channel  = s2_item.channel;
    res.out_byte     = s2_item.data_byte;
    res.in_frame     = 1'b0;
    res.frame_first  = 1'b0;
    res.frame_last   = 1'b0;
    res.frame_length = '0;
    res.frame_code   = '0;
    res.error_kind   = ERR_NONE;
    ctx_next         = cur;

    if (s2_item.restart) begin
      ctx_next = '0;
    end else if (s2_item.in_range && !cur.locked) begin
      if (err_start || bad_len) begin
        res.error_kind  = err_start ? ERR_START : ERR_LENGTH;
        ctx_next        = '0;
        ctx_next.locked = 1'b1;
      end else begin
        res.in_frame      = 1'b1;
        res.frame_first   = (p == POS_START);
        ctx_next.long_hdr = long_new;
        ctx_next.len      = len_new;
        ctx_next.code     = code_new;
        if (have_len && (pos_inc >= {1'b0, len_new})) begin
          res.frame_last   = 1'b1;
          res.frame_length = len_new;
          res.frame_code   = code_new;
          ctx_next.pos     = '0;
        end else begin
          ctx_next.pos = pos_inc[15:0];
        end
      end
    end
  end

endmodule

[sv/lpfs_checker.sv]
// Port-level checks on the frame splitter, bound to the top level.
// Depends on lpfs_pkg and length_prefixed_frame_splitter.
module lpfs_props
  import lpfs_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 empty,
  input logic                 pop,
  input logic [CHANNEL_W-1:0] out_channel,
  input logic [7:0]           out_byte,
  input logic                 in_frame,
  input logic                 frame_first,
  input logic                 frame_last,
  input logic [15:0]          frame_length,
  input logic [7:0]           frame_code,
  input logic [1:0]           error_kind
);

  // no stale results after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending right after reset");

  // a waiting result stays until taken, with channel, byte, length, code and error kind stable
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_channel) && $stable(out_byte)
                          && $stable(frame_length) && $stable(frame_code)
                          && $stable(error_kind)))
    else $error("waiting result changed or vanished");

  // an error item is never part of a frame
  a_err_excl: assert property (@(posedge clk) disable iff (rst)
    (!empty && (error_kind != ERR_NONE)) |->
      (!in_frame && !frame_first && !frame_last && (frame_length == '0)))
    else $error("error item carries frame marks");

  // a frame end is inside a frame and carries a legal length
  a_last_len: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_last) |-> (in_frame && (frame_length >= MIN_FRAME_LEN)))
    else $error("frame end with bad length");

endmodule

bind length_prefixed_frame_splitter lpfs_props u_lpfs_props (.*);
